// ----- src/dq_pkg.sv -----
// shared constants, types and index helper for the double-ended queue
`default_nettype none
package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_EMPTY_POP = 2'd1,
		ST_FULL_PUSH = 2'd2
	} status_t;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [DATA_W-1:0] wr_data;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_front_addr;
		logic [IDX_W-1:0]  rd_back_addr;
	} ram_req_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              fwd_front;
		logic              fwd_back;
		logic [DATA_W-1:0] fwd_data;
	} step_info_t;

	// ring index of a sum below twice the depth
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] adj;
		begin
			adj = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
			return adj[IDX_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ----- src/double_ended_queue_top.sv -----
// top level of the bounded double-ended queue with stream ports
// One action word is taken per cycle while s_tready is high; its result word passes
// through stage one and the output register. A stalled output holds one result in
// stage one and one in the output register. The front and back values come from the
// two read ports of the 16-entry ring memory, read in the cycle the action is taken,
// with a just-written word forwarded. A push on a full queue is dropped and a pop on
// an empty queue is ignored, each flagged in status; front and back read zero when empty.
`default_nettype none
module double_ended_queue_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // value
	input  wire logic [1:0]  s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata    // status, is_empty, entry_count, front_value, back_value
);

	logic                      in_fire;
	logic                      valid_s1;
	logic                      adv_s1;
	logic                      out_valid_q;
	logic [71:0]               out_data_q;
	logic [dq_pkg::DATA_W-1:0] rd_front;
	logic [dq_pkg::DATA_W-1:0] rd_back;
	logic [dq_pkg::DATA_W-1:0] front_val;
	logic [dq_pkg::DATA_W-1:0] back_val;
	logic                      is_empty;
	dq_pkg::ram_req_t          ram_req;
	dq_pkg::step_info_t        info_s1;

	assign s_tready = !valid_s1 || !out_valid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);

	dq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.action  (s_tuser),
		.value   (s_tdata),
		.ram_req (ram_req),
		.info_s1 (info_s1)
	);

	dq_ram #(
		.DATA_W (dq_pkg::DATA_W),
		.ADDR_W (dq_pkg::IDX_W),
		.DEPTH  (dq_pkg::DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (ram_req.wr_en),
		.wr_addr   (ram_req.wr_addr),
		.wr_data   (ram_req.wr_data),
		.rd_en     (ram_req.rd_en),
		.rd_addr_a (ram_req.rd_front_addr),
		.rd_addr_b (ram_req.rd_back_addr),
		.rd_data_a (rd_front),
		.rd_data_b (rd_back)
	);

	always_comb begin
		is_empty  = (info_s1.count == '0);
		front_val = is_empty ? '0 : (info_s1.fwd_front ? info_s1.fwd_data : rd_front);
		back_val  = is_empty ? '0 : (info_s1.fwd_back ? info_s1.fwd_data : rd_back);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {back_val, front_val, info_s1.count, is_empty, info_s1.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[71:8] == '0 && m_tdata[7:3] == '0)
		else $error("empty result with nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("accepted word with both stages full");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

endmodule
`default_nettype wire

// ----- src/dq_ram.sv -----
// generic ram, one write port and two registered read ports
`default_nettype none
module dq_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 4,
	parameter int DEPTH  = 16
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output logic      [DATA_W-1:0] rd_data_a,
	output logic      [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

// ----- src/dq_ctrl.sv -----
// head and count update, ram commands and forwarding info for one action
`default_nettype none
module dq_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_fire,
	input  wire logic [1:0]                 action,
	input  wire logic [dq_pkg::DATA_W-1:0]  value,
	output dq_pkg::ram_req_t                ram_req,
	output dq_pkg::step_info_t              info_s1
);

	logic [dq_pkg::IDX_W-1:0] head_q;
	logic [dq_pkg::CNT_W-1:0] count_q;
	logic [dq_pkg::IDX_W-1:0] head_n;
	logic [dq_pkg::CNT_W-1:0] count_n;
	logic [dq_pkg::IDX_W-1:0] head_dec;
	logic [dq_pkg::IDX_W-1:0] head_inc;
	logic [dq_pkg::IDX_W-1:0] tail_slot;
	logic                     full;
	logic                     empty;
	logic                     wr_en;
	logic [dq_pkg::IDX_W-1:0] wr_addr;
	logic [dq_pkg::IDX_W-1:0] back_addr;
	dq_pkg::status_t          status;
	dq_pkg::action_t          act;

	always_comb begin
		act      = dq_pkg::action_t'(action);
		full     = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
		empty    = (count_q == '0);
		head_dec = (head_q == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : (head_q - 1'b1);
		head_inc = dq_pkg::wrap_idx(dq_pkg::SUM_W'(head_q) + dq_pkg::SUM_W'(1));
		tail_slot = dq_pkg::wrap_idx(dq_pkg::SUM_W'(head_q) + dq_pkg::SUM_W'(count_q));
		head_n   = head_q;
		count_n  = count_q;
		wr_en    = 1'b0;
		wr_addr  = tail_slot;
		status   = dq_pkg::ST_DONE;
		unique case (act)
			dq_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					status = dq_pkg::ST_FULL_PUSH;
				end else begin
					head_n  = head_dec;
					wr_addr = head_dec;
					wr_en   = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			dq_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					status = dq_pkg::ST_FULL_PUSH;
				end else begin
					wr_en   = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			dq_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					status = dq_pkg::ST_EMPTY_POP;
				end else begin
					head_n  = head_inc;
					count_n = count_q - 1'b1;
				end
			end
			dq_pkg::ACT_POP_BACK: begin
				if (empty) begin
					status = dq_pkg::ST_EMPTY_POP;
				end else begin
					count_n = count_q - 1'b1;
				end
			end
		endcase
		back_addr = dq_pkg::wrap_idx(dq_pkg::SUM_W'(head_n) + dq_pkg::SUM_W'(count_n)
			- dq_pkg::SUM_W'(1));

		ram_req.wr_en         = in_fire & wr_en;
		ram_req.wr_addr       = wr_addr;
		ram_req.wr_data       = value;
		ram_req.rd_en         = in_fire;
		ram_req.rd_front_addr = head_n;
		ram_req.rd_back_addr  = back_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (in_fire) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

	// a word written this cycle is not yet visible to the same-cycle read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			info_s1.status    <= status;
			info_s1.count     <= count_n;
			info_s1.fwd_front <= wr_en && (wr_addr == head_n);
			info_s1.fwd_back  <= wr_en && (wr_addr == back_addr);
			info_s1.fwd_data  <= value;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !action[1] && full |=> count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("dropped push changed count");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && action[1] && empty |=> count_q == '0 && $stable(head_q))
		else $error("pop on empty changed state");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !action[1] && !full |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow count");

endmodule
`default_nettype wire

// ----- bench/double_ended_queue_top_tb.sv -----
// self-checking stream testbench for the bounded double-ended queue
module double_ended_queue_top_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 850;
	localparam int DRAIN_CYCLES  = 20;

	typedef struct {
		dq_pkg::action_t act;
		logic [31:0]     val;
	} action_word_t;

	// m_tdata layout, lowest bits last
	typedef struct packed {
		logic [31:0]     back_value;
		logic [31:0]     front_value;
		logic [4:0]      entry_count;
		logic            is_empty;
		dq_pkg::status_t status;
	} result_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;

	action_word_t pending_actions[$];
	result_word_t predicted_results[$];

	logic [31:0] ring_copy[dq_pkg::DEPTH];
	int          ring_head;
	int          ring_held;

	int          error_count;
	int          cycle_count;
	int          gap_left;
	int          burst_left;
	logic [31:0] ready_bits;
	int          ready_age;

	double_ended_queue_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// advance the deque copy by one action and queue the word it should report
	task automatic step_deque(input dq_pkg::action_t act, input logic [31:0] val);
		result_word_t r;
		r = '0;
		r.status = dq_pkg::ST_DONE;
		if (act == dq_pkg::ACT_PUSH_FRONT || act == dq_pkg::ACT_PUSH_BACK) begin
			if (ring_held >= dq_pkg::DEPTH) begin
				r.status = dq_pkg::ST_FULL_PUSH;
			end else if (act == dq_pkg::ACT_PUSH_FRONT) begin
				ring_head = (ring_head + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
				ring_copy[ring_head] = val;
				ring_held++;
			end else begin
				ring_copy[(ring_head + ring_held) % dq_pkg::DEPTH] = val;
				ring_held++;
			end
		end else begin
			if (ring_held == 0) begin
				r.status = dq_pkg::ST_EMPTY_POP;
			end else if (act == dq_pkg::ACT_POP_FRONT) begin
				ring_head = (ring_head + 1) % dq_pkg::DEPTH;
				ring_held--;
			end else begin
				ring_held--;
			end
		end
		r.entry_count = ring_held[4:0];
		r.is_empty = (ring_held == 0);
		if (ring_held != 0) begin
			r.front_value = ring_copy[ring_head];
			r.back_value = ring_copy[(ring_head + ring_held - 1) % dq_pkg::DEPTH];
		end
		predicted_results.insert(predicted_results.size(), r);
	endtask

	task automatic compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			error_count++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left = 0;
			burst_left = 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_actions.size() > 0) begin
				action_word_t w;
				w = pending_actions[0];
				pending_actions.delete(0);
				s_tvalid <= 1'b1;
				s_tdata <= w.val;
				s_tuser <= w.act;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_bits = '1;
			ready_age = 0;
		end else begin
			if (ready_age == 0) begin
				case ($urandom_range(0, 3))
					0: ready_bits = '1;
					1: ready_bits = $urandom;
					2: ready_bits = $urandom & $urandom;
					default: ready_bits = $urandom | $urandom;
				endcase
				ready_age = $urandom_range(16, 80);
			end else begin
				ready_age--;
			end
			ready_bits = {ready_bits[0], ready_bits[31:1]};
			m_tready <= ready_bits[0];
		end
	end

	// monitor: predict on accepted actions, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				step_deque(dq_pkg::action_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				result_word_t want;
				result_word_t got;
				got = m_tdata;
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
					error_count++;
				end else begin
					want = predicted_results[0];
					predicted_results.delete(0);
					compare_field("status", 32'(want.status), 32'(got.status));
					compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
					compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
					compare_field("front_value", want.front_value, got.front_value);
					compare_field("back_value", want.back_value, got.back_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int phase_len;
		int push_pct;
		int made;
		action_word_t w;
		ring_head = 0;
		ring_held = 0;
		error_count = 0;
		cycle_count = 0;
		foreach (ring_copy[i])
			ring_copy[i] = '0;

		// pops on empty, extremes, fill to full, pushes on full, one pop each end
		w.val = 32'h1234_5678;
		w.act = dq_pkg::ACT_POP_FRONT;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_POP_BACK;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_PUSH_FRONT; w.val = 32'h8000_0000;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_PUSH_BACK; w.val = 32'h7fff_ffff;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_PUSH_FRONT; w.val = 32'hffff_ffff;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_PUSH_BACK; w.val = 32'h0000_0000;
		pending_actions.insert(pending_actions.size(), w);
		for (int i = 0; i < dq_pkg::DEPTH - 4; i++) begin
			w.act = (i % 2) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_BACK;
			w.val = $urandom;
			pending_actions.insert(pending_actions.size(), w);
		end
		w.act = dq_pkg::ACT_PUSH_FRONT; w.val = 32'h5555_aaaa;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_PUSH_BACK; w.val = 32'haaaa_5555;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_POP_FRONT;
		pending_actions.insert(pending_actions.size(), w);
		w.act = dq_pkg::ACT_POP_BACK;
		pending_actions.insert(pending_actions.size(), w);

		// phases leaning toward filling, draining or neither
		made = 0;
		while (made < RANDOM_ITEMS) begin
			phase_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: push_pct = 80;
				1: push_pct = 20;
				default: push_pct = 50;
			endcase
			for (int i = 0; i < phase_len && made < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					w.act = $urandom_range(0, 1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
				else
					w.act = $urandom_range(0, 1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT;
				w.val = pick_value();
				pending_actions.insert(pending_actions.size(), w);
				made++;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_actions.size() > 0 || s_tvalid || predicted_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
